@@ sv/dct2d_pkg.sv @@
`default_nettype none

package dct2d_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int B_W        = 17;
  localparam int TI_W       = 4;
  localparam int SPLIT_W    = 24;
  localparam int OUT_SHIFT  = 39;

  // cos(k*pi/2N) in Q14, k = 0..N, one row per block size N = 2..8
  localparam logic [14:0] COS_Q14 [0:6][0:8] = '{
    '{15'd16384, 15'd11585, 15'd0,     15'd0,     15'd0,     15'd0,    15'd0,    15'd0,
      15'd0},
    '{15'd16384, 15'd14189, 15'd8192,  15'd0,     15'd0,     15'd0,    15'd0,    15'd0,
      15'd0},
    '{15'd16384, 15'd15137, 15'd11585, 15'd6270,  15'd0,     15'd0,    15'd0,    15'd0,
      15'd0},
    '{15'd16384, 15'd15582, 15'd13255, 15'd9630,  15'd5063,  15'd0,    15'd0,    15'd0,
      15'd0},
    '{15'd16384, 15'd15826, 15'd14189, 15'd11585, 15'd8192,  15'd4240, 15'd0,    15'd0,
      15'd0},
    '{15'd16384, 15'd15973, 15'd14761, 15'd12810, 15'd10215, 15'd7109, 15'd3646, 15'd0,
      15'd0},
    '{15'd16384, 15'd16069, 15'd15137, 15'd13623, 15'd11585, 15'd9102, 15'd6270, 15'd3196,
      15'd0}
  };

  // normalization weight in Q14: both indexes zero, one zero, none zero
  localparam logic signed [B_W-1:0] W_ONE   = 17'sd16384;
  localparam logic signed [B_W-1:0] W_SQRT2 = 17'sd23170;
  localparam logic signed [B_W-1:0] W_TWO   = 17'sd32768;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7FFF;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;     // update the accumulator
    logic clr;    // start from zero
    logic shift;  // start from accumulator shifted up by SPLIT_W
  } mac_ctl_t;

endpackage

`default_nettype wire

@@ sv/block_dct_2d.sv @@
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+--------------------------------------
// pixel    | in        | in_valid_i/in_ready_o   | pixel_i (8b unsigned, raster order)
// coeff    | out       | out_valid_o/out_ready_i | coefficient_o (16b signed),
//          |           |                         | last_coefficient_o
//
// Pixels are taken one per cycle until a block of N*N is stored; in_ready_o is low while
// the block is transformed. The row pass runs every product on the single multiply-accumulate
// unit and then drains. Each column coefficient takes its products, a drain, normalization
// in two split products, rounding and scaling.
// Reset clears the sequencer, counters and output valid; the stores need no clearing.
// A stalled output holds the transform at its scale step; the last coefficient may wait
// while the next block is being filled.
`default_nettype none

module block_dct_2d #(
  parameter int BLOCK_SIZE = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output      logic                                  in_ready_o,
  input  wire logic [dct2d_pkg::PIX_W-1:0]           pixel_i,
  output      logic                                  out_valid_o,
  input  wire logic                                  out_ready_i,
  output      logic signed [dct2d_pkg::COEF_W-1:0]   coefficient_o,
  output      logic                                  last_coefficient_o
);

  localparam int NPIX   = BLOCK_SIZE * BLOCK_SIZE;
  localparam int ADDR_W = $clog2(NPIX);
  localparam int IDX_W  = $clog2(BLOCK_SIZE);
  localparam int ROW_W  = dct2d_pkg::PIX_W + 15 + IDX_W;
  localparam int S_W    = ROW_W + 14 + IDX_W;
  localparam int A_W    = ROW_W + 2;
  localparam int ACC_W  = S_W + 16;
  localparam int SUM_W  = ACC_W + 1;
  localparam int T_W    = SUM_W - dct2d_pkg::OUT_SHIFT;
  localparam int Lim    = 32768 * BLOCK_SIZE;
  localparam int TC_W   = $clog2(Lim + 1);
  localparam int K_W    = TC_W + 3;
  localparam longint Recip = ((longint'(1) << K_W) + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int PH_W   = $clog2(4 * BLOCK_SIZE);
  localparam int HI_W   = S_W - dct2d_pkg::SPLIT_W;

  localparam logic [ADDR_W-1:0] N_A      = ADDR_W'(BLOCK_SIZE);
  localparam logic [ADDR_W-1:0] PIX_LAST = ADDR_W'(NPIX - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(BLOCK_SIZE - 1);
  localparam logic [PH_W:0]     K1       = (PH_W + 1)'(BLOCK_SIZE);
  localparam logic [PH_W:0]     K2       = (PH_W + 1)'(2 * BLOCK_SIZE);
  localparam logic [PH_W:0]     K3       = (PH_W + 1)'(3 * BLOCK_SIZE);
  localparam logic [PH_W:0]     K4       = (PH_W + 1)'(4 * BLOCK_SIZE);
  localparam logic [2:0]        TAB_ROW  = 3'(BLOCK_SIZE - 2);
  localparam logic [SUM_W-1:0]  RND      =
    SUM_W'(BLOCK_SIZE) << (dct2d_pkg::OUT_SHIFT - 1);
  localparam logic [T_W-1:0]    LIM_T    = T_W'(Lim);
  localparam logic [TC_W-1:0]   LIM_C    = TC_W'(Lim);
  localparam logic [K_W-1:0]    RECIP_V  = K_W'(Recip);

  typedef enum logic [8:0] {
    S_FILL     = 9'b000000001,
    S_ROW      = 9'b000000010,
    S_ROWDRAIN = 9'b000000100,
    S_COL      = 9'b000001000,
    S_COLDRAIN = 9'b000010000,
    S_NHI      = 9'b000100000,
    S_NLO      = 9'b001000000,
    S_ROUND    = 9'b010000000,
    S_SCALE    = 9'b100000000
  } state_e;

  state_e state_d, state_q;

  logic [ADDR_W-1:0] fill_d, fill_q;
  logic [IDX_W-1:0]  hi_d, hi_q, mid_d, mid_q, in_d, in_q;
  logic [PH_W-1:0]   ph_d, ph_q;

  // stores
  logic [dct2d_pkg::PIX_W-1:0] px_mem [NPIX];
  logic signed [ROW_W-1:0]     t_mem  [NPIX];
  logic [dct2d_pkg::PIX_W-1:0] px_rd_q;
  logic signed [ROW_W-1:0]     t_rd_q;
  logic [ADDR_W-1:0]           px_addr, t_addr, dst_addr;

  // operand stage and accumulate stage
  logic                           v1_q, first1_q, last1_q, col1_q;
  logic signed [dct2d_pkg::B_W-1:0] b1_q;
  logic [ADDR_W-1:0]              dst1_q, dst2_q;
  logic                           done_q, col2_q;

  logic                           in_acc, issue, col_mode;
  logic [IDX_W-1:0]               freq;
  logic [PH_W-1:0]                ph_cur;
  logic [PH_W:0]                  ph_sum, kq, tab_sel;
  logic [dct2d_pkg::TI_W-1:0]     ti;
  logic                           cos_neg;
  logic signed [dct2d_pkg::B_W-1:0] cos_mag, basis, weight;

  dct2d_pkg::mac_ctl_t            mac_ctl;
  logic signed [A_W-1:0]          mul_a;
  logic signed [dct2d_pkg::B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]        acc;
  logic signed [HI_W-1:0]         s_hi;
  logic [dct2d_pkg::SPLIT_W-1:0]  lo_q;

  logic [ACC_W-1:0]               mag;
  logic [SUM_W-1:0]               rsum;
  logic [T_W-1:0]                 tval;
  logic [TC_W-1:0]                tc_q;
  logic                           neg_q;
  logic [TC_W+K_W-1:0]            qprod;
  logic [15:0]                    q16;
  logic [16:0]                    nq;
  logic signed [dct2d_pkg::COEF_W-1:0] coef_d, coef_q;
  logic                           ov_q, lastc_q, load, last_coef;

  assign in_ready_o = (state_q == S_FILL);
  assign in_acc     = in_valid_i && in_ready_o;
  assign issue      = (state_q == S_ROW) || (state_q == S_COL);
  assign col_mode   = (state_q == S_COL);
  assign last_coef  = (hi_q == IDX_LAST) && (mid_q == IDX_LAST);
  assign load       = (state_q == S_SCALE) && (!ov_q || out_ready_i);

  assign px_addr  = ADDR_W'(hi_q) * N_A + ADDR_W'(in_q);
  assign dst_addr = ADDR_W'(hi_q) * N_A + ADDR_W'(mid_q);
  assign t_addr   = ADDR_W'(in_q) * N_A + ADDR_W'(mid_q);

  // cosine phase: (2*idx+1)*freq mod 4N, advanced by 2*freq per product
  always_comb begin
    freq   = col_mode ? hi_q : mid_q;
    ph_cur = (in_q == '0) ? PH_W'(freq) : ph_q;
    ph_sum = {1'b0, ph_cur} + (PH_W + 1)'({freq, 1'b0});
    if (ph_sum >= K4) begin
      ph_d = PH_W'(ph_sum - K4);
    end else begin
      ph_d = PH_W'(ph_sum);
    end
    kq = {1'b0, ph_cur};
    priority if (kq <= K1) begin
      tab_sel = kq;
      cos_neg = 1'b0;
    end else if (kq <= K2) begin
      tab_sel = K2 - kq;
      cos_neg = 1'b1;
    end else if (kq <= K3) begin
      tab_sel = kq - K2;
      cos_neg = 1'b1;
    end else begin
      tab_sel = K4 - kq;
      cos_neg = 1'b0;
    end
    ti      = tab_sel[dct2d_pkg::TI_W-1:0];
    cos_mag = dct2d_pkg::B_W'(dct2d_pkg::COS_Q14[TAB_ROW][ti]);
    basis   = cos_neg ? -cos_mag : cos_mag;
  end

  always_comb begin
    priority if (hi_q == '0 && mid_q == '0) begin
      weight = dct2d_pkg::W_ONE;
    end else if (hi_q == '0 || mid_q == '0) begin
      weight = dct2d_pkg::W_SQRT2;
    end else begin
      weight = dct2d_pkg::W_TWO;
    end
  end

  // operand selection for the shared unit
  assign s_hi = acc[S_W-1:dct2d_pkg::SPLIT_W];

  always_comb begin
    mac_ctl = '0;
    mul_a   = '0;
    mul_b   = weight;
    priority if (v1_q) begin
      mac_ctl.en  = 1'b1;
      mac_ctl.clr = first1_q;
      mul_a       = col1_q ? A_W'(t_rd_q) : A_W'({1'b0, px_rd_q});
      mul_b       = b1_q;
    end else if (state_q == S_NHI) begin
      mac_ctl.en  = 1'b1;
      mac_ctl.clr = 1'b1;
      mul_a       = A_W'(s_hi);
    end else if (state_q == S_NLO) begin
      mac_ctl.en    = 1'b1;
      mac_ctl.shift = 1'b1;
      mul_a         = A_W'({1'b0, lo_q});
    end else begin
      mac_ctl = '0;
    end
  end

  dct2d_mac #(
    .A_W   (A_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .acc_o (acc)
  );

  // rounding: floor((|x| + N*2^38) / 2^39) / N, clamped before the divide
  always_comb begin
    mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    rsum = {1'b0, mag} + RND;
    tval = rsum[SUM_W-1:dct2d_pkg::OUT_SHIFT];
    qprod = tc_q * RECIP_V;
    q16   = qprod[K_W+15:K_W];
    nq    = -{1'b0, q16};
    if (neg_q) begin
      coef_d = nq[15:0];
    end else if (q16[15]) begin
      coef_d = dct2d_pkg::COEF_MAX;
    end else begin
      coef_d = q16;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    in_d    = in_q;
    unique case (state_q)
      S_FILL: begin
        if (in_acc) begin
          if (fill_q == PIX_LAST) begin
            fill_d  = '0;
            hi_d    = '0;
            mid_d   = '0;
            in_d    = '0;
            state_d = S_ROW;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      S_ROW: begin
        in_d = in_q + 1'b1;
        if (in_q == IDX_LAST) begin
          in_d  = '0;
          mid_d = mid_q + 1'b1;
          if (mid_q == IDX_LAST) begin
            mid_d = '0;
            hi_d  = hi_q + 1'b1;
            if (hi_q == IDX_LAST) begin
              hi_d    = '0;
              state_d = S_ROWDRAIN;
            end
          end
        end
      end
      S_ROWDRAIN: begin
        // wait for the last row sum to land in the store
        if (!v1_q && !done_q) begin
          state_d = S_COL;
        end
      end
      S_COL: begin
        in_d = in_q + 1'b1;
        if (in_q == IDX_LAST) begin
          in_d    = '0;
          state_d = S_COLDRAIN;
        end
      end
      S_COLDRAIN: begin
        if (done_q) begin
          state_d = S_NHI;
        end
      end
      S_NHI:   state_d = S_NLO;
      S_NLO:   state_d = S_ROUND;
      S_ROUND: state_d = S_SCALE;
      S_SCALE: begin
        if (load) begin
          if (last_coef) begin
            hi_d    = '0;
            mid_d   = '0;
            state_d = S_FILL;
          end else begin
            state_d = S_COL;
            mid_d   = mid_q + 1'b1;
            if (mid_q == IDX_LAST) begin
              mid_d = '0;
              hi_d  = hi_q + 1'b1;
            end
          end
        end
      end
      default: state_d = S_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
      fill_q  <= '0;
      hi_q    <= '0;
      mid_q   <= '0;
      in_q    <= '0;
      v1_q    <= 1'b0;
      done_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      hi_q    <= hi_d;
      mid_q   <= mid_d;
      in_q    <= in_d;
      v1_q    <= issue;
      done_q  <= v1_q && last1_q;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (issue) begin
      ph_q     <= ph_d;
      b1_q     <= basis;
      first1_q <= (in_q == '0);
      last1_q  <= (in_q == IDX_LAST);
      col1_q   <= col_mode;
      dst1_q   <= dst_addr;
    end
    dst2_q <= dst1_q;
    col2_q <= col1_q;
    if (state_q == S_NHI) begin
      lo_q <= acc[dct2d_pkg::SPLIT_W-1:0];
    end
    if (state_q == S_ROUND) begin
      neg_q <= acc[ACC_W-1];
      tc_q  <= (tval > LIM_T) ? LIM_C : TC_W'(tval);
    end
    if (load) begin
      coef_q  <= coef_d;
      lastc_q <= last_coef;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_mem[fill_q] <= pixel_i;
    end
    px_rd_q <= px_mem[px_addr];
  end

  always_ff @(posedge clk_i) begin
    if (done_q && !col2_q) begin
      t_mem[dst2_q] <= acc[ROW_W-1:0];
    end
    t_rd_q <= t_mem[t_addr];
  end

  assign out_valid_o        = ov_q;
  assign coefficient_o      = coef_q;
  assign last_coefficient_o = lastc_q;

  a_pipe_in_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (state_q == S_ROW || state_q == S_ROWDRAIN ||
              state_q == S_COL || state_q == S_COLDRAIN))
    else $error("product stage active outside a pass");

  a_col_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && col2_q) |-> (state_q == S_COLDRAIN))
    else $error("column sum finished outside drain");

  a_block_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_coef) |=> (state_q == S_FILL))
    else $error("last coefficient did not return to fill");

  a_fill_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FILL) |-> (fill_q == '0))
    else $error("fill count nonzero during transform");

endmodule

`default_nettype wire

@@ sv/dct2d_mac.sv @@
`default_nettype none

module dct2d_mac #(
  parameter int A_W   = 28,
  parameter int ACC_W = 59
) (
  input  wire logic                               clk_i,
  input  wire dct2d_pkg::mac_ctl_t                ctl_i,
  input  wire logic signed [A_W-1:0]              a_i,
  input  wire logic signed [dct2d_pkg::B_W-1:0]   b_i,
  output      logic signed [ACC_W-1:0]            acc_o
);

  logic signed [A_W+dct2d_pkg::B_W-1:0] prod;
  logic signed [ACC_W-1:0]              base;
  logic signed [ACC_W-1:0]              acc_d, acc_q;

  assign prod = a_i * b_i;

  always_comb begin
    priority if (ctl_i.clr) begin
      base = '0;
    end else if (ctl_i.shift) begin
      base = acc_q <<< dct2d_pkg::SPLIT_W;
    end else begin
      base = acc_q;
    end
    acc_d = base + ACC_W'(prod);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire
